@@ design/boy_pkg.sv @@
// Shared types, constants and fixed-point helpers for the Boy surface colorizer.
package boy_pkg;

    // Q16 working format
    localparam int QB        = 16;
    localparam int QONE      = 1 << QB;
    localparam int HALF      = 1 << (QB - 1);
    localparam int CLAMP_LIM = 2 << QB;

    // input coordinate format
    localparam int COORD_W         = 16;
    localparam int COORD_FRAC_BITS = 14;

    // default color depth
    localparam int COLOR_BITS_DEF = 16;

    localparam int NUM_TERMS = 12;
    localparam int NUM_CH    = 3;
    localparam int MIX_N     = 8;
    localparam int MIXZ_N    = 4;

    // term normalizers, Q16
    localparam int K_P1   = 20739;
    localparam int K_XZ   = 71624;
    localparam int K_DIFF = 35812;
    localparam int K_XY   = 71494;
    localparam int K_P6   = 6966;
    localparam int K_P7   = 43843;
    localparam int K_P9   = 31011;
    localparam int K_P10  = 62021;
    localparam int K_P11  = 116003;

    // widths of the datapath
    localparam int Q_W    = 19;   // clamped coordinate, +-2.0
    localparam int P_W    = 22;   // products of degree two to four
    localparam int W_W    = 28;   // polynomials and terms
    localparam int COEF_W = 19;
    localparam int PROD_W = W_W + COEF_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int V_W    = ACC_W - QB;
    localparam int GAIN_W = 15;
    localparam int MQ_W   = 48;

    typedef logic signed [COORD_W-1:0] t_raw;
    typedef logic signed [Q_W-1:0]     t_q;
    typedef logic signed [P_W-1:0]     t_p;
    typedef logic signed [W_W-1:0]     t_w;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [V_W-1:0]     t_v;
    typedef logic [GAIN_W-1:0]         t_gain;
    typedef logic signed [MQ_W-1:0]    t_mq;
    typedef logic [3:0]                t_tidx;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // X/Y mixing: term index and rotation weight for each product
    localparam t_tidx MIX_XY_SRC [MIX_N] = '{4'd1, 4'd2, 4'd4, 4'd3, 4'd6, 4'd7, 4'd9, 4'd8};
    localparam t_coef MIX_X_COEF [MIX_N] = '{
        19'sd163484, -19'sd69395, -19'sd93147, -19'sd103087,
        -19'sd20739, -19'sd60230, -19'sd32628, 19'sd46598};
    localparam t_coef MIX_Y_COEF [MIX_N] = '{
        19'sd69395, 19'sd163484, 19'sd103087, -19'sd93147,
        19'sd60230, -19'sd20739, -19'sd46598, -19'sd32628};

    // Z mixing
    localparam t_tidx MIX_Z_SRC  [MIXZ_N] = '{4'd0, 4'd5, 4'd10, 4'd11};
    localparam t_coef MIX_Z_COEF [MIXZ_N] = '{
        -19'sd183501, -19'sd32768, 19'sd19661, -19'sd163840};

    // per channel offset and gain (0.9 / width), Q16
    localparam t_v    CH_TRL  [NUM_CH] = '{-34'sd133857, -34'sd121510, -34'sd143517};
    localparam t_gain CH_GAIN [NUM_CH] = '{15'd14069, 15'd14666, 15'd14494};
    localparam int    OFFS = 3277;

    // Q16 product, rounded half up
    function automatic t_mq mulq(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'(HALF);
        return $signed(p[63:QB]);
    endfunction

endpackage

@@ design/boy_terms.sv @@
// Coordinate conversion and the twelve polynomial terms, five register stages.
module boy_terms (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  boy_pkg::t_ctl  i_ctl,
    input  boy_pkg::t_raw  i_x,
    input  boy_pkg::t_raw  i_y,
    input  boy_pkg::t_raw  i_z,
    output boy_pkg::t_ctl  o_ctl,
    output boy_pkg::t_w    o_h [boy_pkg::NUM_TERMS]
);
    import boy_pkg::*;

    localparam int SH_L = (COORD_FRAC_BITS < QB) ? QB - COORD_FRAC_BITS : 0;
    localparam int SH_R = (COORD_FRAC_BITS > QB) ? COORD_FRAC_BITS - QB : 0;
    localparam int RND  = (SH_R > 0) ? (1 << (SH_R - 1)) : 0;
    localparam int CV_W = COORD_W + SH_L + 2;
    localparam int NSTG = 5;

    // bring to Q16 with round half up, clamp to +-2.0
    function automatic t_q to_q16(input t_raw raw);
        logic signed [CV_W-1:0] ext;
        logic signed [CV_W-1:0] sh;
        ext = raw;
        sh  = ((ext <<< SH_L) + CV_W'(RND)) >>> SH_R;
        if (sh > CLAMP_LIM) begin
            return t_q'(CLAMP_LIM);
        end else if (sh < -CLAMP_LIM) begin
            return t_q'(-CLAMP_LIM);
        end
        return t_q'(sh);
    endfunction

    t_ctl r_ctl [NSTG];

    // stage 0
    t_q r0_x, r0_y, r0_z;
    // stage 1
    t_q r1_x, r1_y, r1_z;
    t_p r1_x2, r1_y2, r1_z2, r1_xy, r1_xz, r1_yz;
    // stage 2
    t_q r2_x, r2_y, r2_z;
    t_p r2_z2, r2_z3, r2_z4, r2_x3, r2_y3, r2_xy, r2_xz, r2_yz, r2_diff;
    t_w r2_u, r2_w;
    t_w r2_h [5];
    // stage 3
    t_w r3_xt, r3_yt, r3_du, r3_xyu, r3_x3z, r3_xzw, r3_yzw, r3_y3z, r3_p6;
    t_w r3_h [5];
    // stage 4
    t_w r4_h [NUM_TERMS];

    t_w w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_ctl[i].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int i = 1; i < NSTG; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    assign w_t = t_w'(7 * r2_z3 - 3 * r2_z);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_x <= to_q16(i_x);
            r0_y <= to_q16(i_y);
            r0_z <= to_q16(i_z);

            r1_x  <= r0_x;
            r1_y  <= r0_y;
            r1_z  <= r0_z;
            r1_x2 <= t_p'(mulq(r0_x, r0_x));
            r1_y2 <= t_p'(mulq(r0_y, r0_y));
            r1_z2 <= t_p'(mulq(r0_z, r0_z));
            r1_xy <= t_p'(mulq(r0_x, r0_y));
            r1_xz <= t_p'(mulq(r0_x, r0_z));
            r1_yz <= t_p'(mulq(r0_y, r0_z));

            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_z    <= r1_z;
            r2_z2   <= r1_z2;
            r2_xy   <= r1_xy;
            r2_xz   <= r1_xz;
            r2_yz   <= r1_yz;
            r2_z3   <= t_p'(mulq(r1_z2, r1_z));
            r2_z4   <= t_p'(mulq(r1_z2, r1_z2));
            r2_x3   <= t_p'(mulq(r1_x2, r1_x));
            r2_y3   <= t_p'(mulq(r1_y2, r1_y));
            r2_diff <= t_p'(r1_x2 - r1_y2);
            r2_u    <= t_w'(7 * r1_z2 - QONE);
            r2_w    <= t_w'(QONE - r1_z2);
            r2_h[0] <= t_w'(mulq(3 * r1_z2 - QONE, K_P1));
            r2_h[1] <= t_w'(mulq(r1_xz, K_XZ));
            r2_h[2] <= t_w'(mulq(r1_yz, K_XZ));
            r2_h[3] <= t_w'(mulq(r1_x2 - r1_y2, K_DIFF));
            r2_h[4] <= t_w'(mulq(r1_xy, K_XY));

            r3_xt  <= t_w'(mulq(r2_x, w_t));
            r3_yt  <= t_w'(mulq(r2_y, w_t));
            r3_du  <= t_w'(mulq(r2_diff, r2_u));
            r3_xyu <= t_w'(mulq(r2_xy, r2_u));
            r3_x3z <= t_w'(mulq(r2_x3, r2_z));
            r3_xzw <= t_w'(mulq(r2_xz, r2_w));
            r3_yzw <= t_w'(mulq(r2_yz, r2_w));
            r3_y3z <= t_w'(mulq(r2_y3, r2_z));
            r3_p6  <= t_w'(35 * r2_z4 - 30 * r2_z2 + 3 * QONE);
            r3_h   <= r2_h;

            for (int i = 0; i < 5; i++) begin
                r4_h[i] <= r3_h[i];
            end
            r4_h[5]  <= t_w'(mulq(r3_p6, K_P6));
            r4_h[6]  <= t_w'(mulq(r3_xt, K_P7));
            r4_h[7]  <= t_w'(mulq(r3_yt, K_P7));
            r4_h[8]  <= t_w'(mulq(r3_du, K_P9));
            r4_h[9]  <= t_w'(mulq(r3_xyu, K_P10));
            r4_h[10] <= t_w'(mulq(4 * r3_x3z - 3 * r3_xzw, K_P11));
            r4_h[11] <= t_w'(mulq(3 * r3_yzw - 4 * r3_y3z, K_P11));
        end
    end

    assign o_ctl = r_ctl[NSTG-1];
    assign o_h   = r4_h;

endmodule

@@ design/boy_mix.sv @@
// Rotation mix of the terms into X, Y, Z: products, half sums, final sum.
module boy_mix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  boy_pkg::t_ctl  i_ctl,
    input  boy_pkg::t_w    i_h [boy_pkg::NUM_TERMS],
    output boy_pkg::t_ctl  o_ctl,
    output boy_pkg::t_v    o_v [boy_pkg::NUM_CH]
);
    import boy_pkg::*;

    localparam int NSTG = 3;

    t_ctl  r_ctl [NSTG];
    t_prod n_px [MIX_N];
    t_prod n_py [MIX_N];
    t_prod n_pz [MIXZ_N];
    t_prod r_px [MIX_N];
    t_prod r_py [MIX_N];
    t_prod r_pz [MIXZ_N];
    t_acc  r_sx [2];
    t_acc  r_sy [2];
    t_acc  r_sz [2];
    t_acc  w_acc [NUM_CH];
    t_v    r_v [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_ctl[i].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int i = 1; i < NSTG; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MIX_N; i++) begin
            n_px[i] = i_h[MIX_XY_SRC[i]] * MIX_X_COEF[i];
            n_py[i] = i_h[MIX_XY_SRC[i]] * MIX_Y_COEF[i];
        end
        for (int i = 0; i < MIXZ_N; i++) begin
            n_pz[i] = i_h[MIX_Z_SRC[i]] * MIX_Z_COEF[i];
        end
    end

    // final sum with the rounding bias folded in
    always_comb begin
        w_acc[0] = r_sx[0] + r_sx[1] + ACC_W'(HALF);
        w_acc[1] = r_sy[0] + r_sy[1] + ACC_W'(HALF);
        w_acc[2] = r_sz[0] + r_sz[1] + ACC_W'(HALF);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
            for (int k = 0; k < 2; k++) begin
                r_sx[k] <= r_px[4*k] + r_px[4*k+1] + r_px[4*k+2] + r_px[4*k+3];
                r_sy[k] <= r_py[4*k] + r_py[4*k+1] + r_py[4*k+2] + r_py[4*k+3];
                r_sz[k] <= r_pz[2*k] + r_pz[2*k+1];
            end
            for (int c = 0; c < NUM_CH; c++) begin
                r_v[c] <= $signed(w_acc[c][ACC_W-1:QB]);
            end
        end
    end

    assign o_ctl = r_ctl[NSTG-1];
    assign o_v   = r_v;

endmodule

@@ design/boy_chan.sv @@
// Channel scaling: |V - offset| * gain + bias, then scale to color depth, saturating at 1.0.
module boy_chan #(
    parameter int COLOR_BITS = boy_pkg::COLOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  boy_pkg::t_ctl         i_ctl,
    input  boy_pkg::t_v           i_v [boy_pkg::NUM_CH],
    output boy_pkg::t_ctl         o_ctl,
    output logic [COLOR_BITS-1:0] o_color [boy_pkg::NUM_CH]
);
    import boy_pkg::*;

    localparam int NSTG = 2;
    localparam int PR_W = V_W + GAIN_W + 1;
    localparam int C_W  = PR_W - QB + 1;
    localparam int S_W  = QB + COLOR_BITS + 1;
    localparam logic [COLOR_BITS-1:0] MAXC = '1;

    t_ctl                   r_ctl [NSTG];
    logic signed [V_W:0]    w_d   [NUM_CH];
    logic signed [V_W:0]    w_abs [NUM_CH];
    logic [PR_W-1:0]        w_prod [NUM_CH];
    logic [C_W-1:0]         w_c   [NUM_CH];
    logic [S_W-1:0]         w_s   [NUM_CH];
    logic [QB-1:0]          r_c   [NUM_CH];
    logic                   r_sat [NUM_CH];
    logic [COLOR_BITS-1:0]  r_col [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_ctl[i].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            r_ctl[1] <= r_ctl[0];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            w_d[i]    = i_v[i] - CH_TRL[i];
            w_abs[i]  = (w_d[i] < 0) ? -w_d[i] : w_d[i];
            w_prod[i] = w_abs[i][V_W-1:0] * CH_GAIN[i] + PR_W'(HALF);
            w_c[i]    = C_W'(w_prod[i][PR_W-1:QB]) + C_W'(OFFS);
            w_s[i]    = r_c[i] * MAXC + S_W'(HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_c[i]   <= w_c[i][QB-1:0];
                r_sat[i] <= (w_c[i] >= C_W'(QONE));
                r_col[i] <= r_sat[i] ? MAXC : w_s[i][QB+COLOR_BITS-1:QB];
            end
        end
    end

    assign o_ctl   = r_ctl[NSTG-1];
    assign o_color = r_col;

endmodule

@@ design/boy_surface_direction_to_rgb.sv @@
// Top level: Boy surface direction-to-RGB colorizer, streaming in and out.
//
// Slave stream: one word per unit direction, x/y/z signed Q1.14 in tdata,
// tlast marks the end of a batch. Master stream: one word per direction with
// red/green/blue unsigned channels (all ones = 1.0, saturating) and the
// copied tlast.
// Throughput: one word per cycle while the output is not stalled. The
// pipeline is 5 stages of term polynomials (input conversion, then one
// Q16 multiply per stage), 3 stages of rotation mix (products, half sums,
// final rounded sum) and 2 stages of channel scaling; the last of these is
// the output register.
// Stall: the whole pipeline advances as one while the output register is
// empty or being taken. When the receiver holds tready low with a word
// waiting, every stage freezes and o_s_axis_tready drops in the same cycle;
// nothing is lost or repeated. Bubbles upstream of a full output register
// are not squeezed out.
// Reset (synchronous, active low) clears all valid bits; data registers are
// not reset. No state is carried between words.
module boy_surface_direction_to_rgb #(
    parameter int COLOR_BITS = boy_pkg::COLOR_BITS_DEF,
    localparam int OUT_W = ((3 * COLOR_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // slave side
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [47:0]      i_s_axis_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    input  logic             i_s_axis_tlast,   // in_last
    // master side
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // red, green, blue (COLOR_BITS each), zero pad
    output logic             o_m_axis_tlast    // out_last
);
    import boy_pkg::*;

    logic                  w_en;
    t_ctl                  w_in_ctl;
    t_ctl                  w_terms_ctl;
    t_ctl                  w_mix_ctl;
    t_ctl                  w_out_ctl;
    t_w                    w_h [NUM_TERMS];
    t_v                    w_v [NUM_CH];
    logic [COLOR_BITS-1:0] w_color [NUM_CH];

    // global advance: output register free or being drained
    assign w_en            = !w_out_ctl.valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_in_ctl.valid = i_s_axis_tvalid;
    assign w_in_ctl.last  = i_s_axis_tlast;

    boy_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_in_ctl),
        .i_x     (i_s_axis_tdata[15:0]),
        .i_y     (i_s_axis_tdata[31:16]),
        .i_z     (i_s_axis_tdata[47:32]),
        .o_ctl   (w_terms_ctl),
        .o_h     (w_h)
    );

    boy_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_terms_ctl),
        .i_h     (w_h),
        .o_ctl   (w_mix_ctl),
        .o_v     (w_v)
    );

    boy_chan #(
        .COLOR_BITS (COLOR_BITS)
    ) u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_mix_ctl),
        .i_v     (w_v),
        .o_ctl   (w_out_ctl),
        .o_color (w_color)
    );

    assign o_m_axis_tvalid = w_out_ctl.valid;
    assign o_m_axis_tlast  = w_out_ctl.last;
    assign o_m_axis_tdata  = OUT_W'({w_color[2], w_color[1], w_color[0]});

endmodule

@@ design/boy_checker.sv @@
// Port-level checks for the colorizer, bound to the top level.
module boy_checker #(
    parameter int COLOR_BITS = boy_pkg::COLOR_BITS_DEF,
    localparam int OUT_W = ((3 * COLOR_BITS + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    // empty output stage never back-pressures the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    // a draining receiver never stalls the input
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while receiver ready");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind boy_surface_direction_to_rgb boy_checker #(
    .COLOR_BITS (COLOR_BITS)
) u_boy_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

@@ verif/boy_color_checker.sv @@
// Checker for the Boy surface colorizer: watches both streams, predicts each color and compares.
`timescale 1ns / 1ps

module boy_color_checker #(
    parameter int COLOR_BITS = boy_pkg::COLOR_BITS_DEF,
    parameter int OUT_W      = ((3 * COLOR_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [47:0]      i_s_tdata,    // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    input  logic             i_s_tlast,    // in_last
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,    // red, green, blue, zero pad
    input  logic             i_m_tlast,    // out_last
    output int               o_errors,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic                  last;
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
    } rgb_t;

    localparam int     FQ   = 16;
    localparam longint ONE  = longint'(1) <<< FQ;
    localparam longint LIM2 = longint'(2) <<< FQ;

    // term normalizers
    localparam longint N_ZONAL2 = 20739;
    localparam longint N_XZ     = 71624;
    localparam longint N_DIFF   = 35812;
    localparam longint N_XY     = 71494;
    localparam longint N_ZONAL4 = 6966;
    localparam longint N_Z3     = 43843;
    localparam longint N_DU     = 31011;
    localparam longint N_XYU    = 62021;
    localparam longint N_DEG4   = 116003;

    // rotation weights
    localparam longint R_C23 = 163484;
    localparam longint R_S23 = -69395;
    localparam longint R_C45 = -93147;
    localparam longint R_S45 = -103087;
    localparam longint R_C67 = -20739;
    localparam longint R_S67 = -60230;
    localparam longint R_C89 = -32628;
    localparam longint R_S89 = 46598;

    localparam longint ZW_1  = -183501;
    localparam longint ZW_6  = -32768;
    localparam longint ZW_11 = 19661;
    localparam longint ZW_12 = -163840;

    localparam longint OFS_R = -133857;
    localparam longint OFS_G = -121510;
    localparam longint OFS_B = -143517;
    localparam longint GN_R  = 14069;
    localparam longint GN_G  = 14666;
    localparam longint GN_B  = 14494;
    localparam longint BIAS  = 3277;

    rgb_t exp_colors [$];
    int   n_err;
    int   n_chk;

    // round half up of v / 2^s
    function automatic longint rnd_sh(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return rnd_sh(a * b, FQ);
    endfunction

    // Q1.14 raw to Q16, clamped to +-2.0
    function automatic longint to_q(input logic [15:0] raw);
        longint v;
        v = longint'($signed(raw)) * (longint'(1) <<< (FQ - boy_pkg::COORD_FRAC_BITS));
        if (v > LIM2)
            v = LIM2;
        if (v < -LIM2)
            v = -LIM2;
        return v;
    endfunction

    function automatic logic [COLOR_BITS-1:0] to_channel(input longint v, input longint ofs,
                                                         input longint gain);
        longint d;
        longint c;
        longint maxc;
        maxc = (longint'(1) <<< COLOR_BITS) - 1;
        d = v - ofs;
        if (d < 0)
            d = -d;
        c = rnd_sh(d * gain, FQ) + BIAS;
        if (c >= ONE)
            return maxc[COLOR_BITS-1:0];
        return COLOR_BITS'(rnd_sh(c * maxc, FQ));
    endfunction

    function automatic rgb_t boy_color(input logic [47:0] dir, input logic lst);
        longint x, y, z, x2, y2, z2, xy, xz, yz, z3, z4, x3, y3, dif, t3, u7, w1;
        longint h1, h2, h3, h4, h5, h6, h7, h8, h9, h10, h11, h12;
        longint vx, vy, vz;
        rgb_t   r;
        x   = to_q(dir[15:0]);
        y   = to_q(dir[31:16]);
        z   = to_q(dir[47:32]);
        x2  = qmul(x, x);
        y2  = qmul(y, y);
        z2  = qmul(z, z);
        xy  = qmul(x, y);
        xz  = qmul(x, z);
        yz  = qmul(y, z);
        z3  = qmul(z2, z);
        z4  = qmul(z2, z2);
        x3  = qmul(x2, x);
        y3  = qmul(y2, y);
        dif = x2 - y2;
        t3  = 7 * z3 - 3 * z;
        u7  = 7 * z2 - ONE;
        w1  = ONE - z2;

        h1  = qmul(3 * z2 - ONE, N_ZONAL2);
        h2  = qmul(xz, N_XZ);
        h3  = qmul(yz, N_XZ);
        h4  = qmul(dif, N_DIFF);
        h5  = qmul(xy, N_XY);
        h6  = qmul(35 * z4 - 30 * z2 + 3 * ONE, N_ZONAL4);
        h7  = qmul(qmul(x, t3), N_Z3);
        h8  = qmul(qmul(y, t3), N_Z3);
        h9  = qmul(qmul(dif, u7), N_DU);
        h10 = qmul(qmul(xy, u7), N_XYU);
        h11 = qmul(4 * qmul(x3, z) - 3 * qmul(xz, w1), N_DEG4);
        h12 = qmul(3 * qmul(yz, w1) - 4 * qmul(y3, z), N_DEG4);

        vx = rnd_sh(h2 * R_C23 + h3 * R_S23 + h5 * R_C45 + h4 * R_S45
                  + h7 * R_C67 + h8 * R_S67 + h10 * R_C89 + h9 * R_S89, FQ);
        vy = rnd_sh(-h2 * R_S23 + h3 * R_C23 - h5 * R_S45 + h4 * R_C45
                  - h7 * R_S67 + h8 * R_C67 - h10 * R_S89 + h9 * R_C89, FQ);
        vz = rnd_sh(h1 * ZW_1 + h6 * ZW_6 + h11 * ZW_11 + h12 * ZW_12, FQ);

        r.red   = to_channel(vx, OFS_R, GN_R);
        r.green = to_channel(vy, OFS_G, GN_G);
        r.blue  = to_channel(vz, OFS_B, GN_B);
        r.last  = lst;
        return r;
    endfunction

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            n_err++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    initial begin
        n_err     = 0;
        n_chk     = 0;
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin
        rgb_t want;
        rgb_t got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                exp_colors.push_back(boy_color(i_s_tdata, i_s_tlast));
            if (i_m_tvalid && i_m_tready) begin
                got.red   = i_m_tdata[COLOR_BITS-1:0];
                got.green = i_m_tdata[2*COLOR_BITS-1:COLOR_BITS];
                got.blue  = i_m_tdata[3*COLOR_BITS-1:2*COLOR_BITS];
                got.last  = i_m_tlast;
                if (exp_colors.size() == 0) begin
                    n_err++;
                    $display("%0t ns: unexpected output word, expected none actual %h",
                             $time, got);
                end else begin
                    want = exp_colors.pop_front();
                    cmp_field("red", int'(want.red), int'(got.red));
                    cmp_field("green", int'(want.green), int'(got.green));
                    cmp_field("blue", int'(want.blue), int'(got.blue));
                    cmp_field("tlast", int'(want.last), int'(got.last));
                    n_chk++;
                end
            end
        end
        o_errors  <= n_err;
        o_pending <= exp_colors.size();
        o_checked <= n_chk;
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the Boy surface colorizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int COLOR_BITS = boy_pkg::COLOR_BITS_DEF;
    localparam int OUT_W      = ((3 * COLOR_BITS + 7) / 8) * 8;
    localparam int N_HOLD     = 40;     // words pushed into the held-off sink
    localparam int N_RAND     = 560;    // random words with idling
    localparam int N_QUIET    = 100;    // final words, no idling anywhere
    localparam int HOLD_CYC   = 300;    // long sink hold-off
    localparam int DRAIN_CYC  = 30;     // pipeline is 10 deep
    localparam int LIMIT      = 200000; // timeout bound for the hard stop below
    localparam int N_CORNER   = 18;

    // corner directions, packed {z, y, x}
    localparam logic [47:0] CORNERS [N_CORNER] = '{
        {16'h0000, 16'h0000, 16'h0000},     // zero vector
        {16'h0000, 16'h0000, 16'h4000},     // +x
        {16'h0000, 16'h0000, 16'hC000},     // -x
        {16'h0000, 16'h4000, 16'h0000},     // +y
        {16'h0000, 16'hC000, 16'h0000},     // -y
        {16'h4000, 16'h0000, 16'h0000},     // +z
        {16'hC000, 16'h0000, 16'h0000},     // -z
        {16'h24F3, 16'h24F3, 16'h24F3},     // unit diagonal
        {16'hDB0D, 16'hDB0D, 16'hDB0D},     // opposite diagonal
        {16'h7FFF, 16'h7FFF, 16'h7FFF},     // most positive raw
        {16'h8000, 16'h8000, 16'h8000},     // most negative raw, exactly -2.0
        {16'h7FFF, 16'h8000, 16'h7FFF},
        {16'h8000, 16'h7FFF, 16'h8000},
        {16'h4000, 16'h4000, 16'h4000},     // non-unit, length sqrt(3)
        {16'hFFFF, 16'h0001, 16'hFFFF},     // nearly zero
        {16'h0000, 16'h2D41, 16'h2D41},     // xy plane
        {16'h2D41, 16'h0000, 16'h2D41},     // xz plane
        {16'h2D41, 16'hD2BF, 16'h0000}      // yz plane
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [47:0]      s_tdata;    // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    logic             s_tlast;    // in_last
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;    // red, green, blue
    logic             m_tlast;    // out_last

    int errors;
    int pending;
    int checked;
    int n_sent;
    int cycles;

    // sink control: hold_go is written by the source side only, hold_done by
    // the sink only; quiet switches off all idling for the tail of the run
    logic hold_go;
    logic hold_done;
    logic quiet;

    boy_surface_direction_to_rgb #(
        .COLOR_BITS(COLOR_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast)
    );

    boy_color_checker #(
        .COLOR_BITS(COLOR_BITS),
        .OUT_W     (OUT_W)
    ) i_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tlast (s_tlast),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_m_tdata (m_tdata),
        .i_m_tlast (m_tlast),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop: only reached if the run hangs
    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
        $display("FAIL boy_surface_direction_to_rgb");
        $finish;
    end

    // one random direction, packed {z, y, x}
    //  - mostly unit vectors in any direction (the normal use)
    //  - some raw 16-bit words over the whole range, so every bit toggles
    //  - some large components near +-2.0 to drive the channels into saturation
    function automatic logic [47:0] pick_dir();
        real a, b, c, n;
        int  mode;
        logic [15:0] px, py, pz;
        mode = $urandom_range(0, 19);
        if (mode < 15) begin
            n = 0.0;
            while (n < 0.01) begin
                a = real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
                b = real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
                c = real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
                n = $sqrt(a * a + b * b + c * c);
            end
            px = 16'($rtoi(a / n * 16384.0));
            py = 16'($rtoi(b / n * 16384.0));
            pz = 16'($rtoi(c / n * 16384.0));
        end else if (mode < 18) begin
            px = 16'($urandom);
            py = 16'($urandom);
            pz = 16'($urandom);
        end else begin
            px = 16'($urandom_range(24000, 32767));
            py = 16'($urandom_range(24000, 32767));
            pz = 16'($urandom_range(24000, 32767));
            if ($urandom_range(0, 1)) px = -px;
            if ($urandom_range(0, 1)) py = -py;
            if ($urandom_range(0, 1)) pz = -pz;
        end
        return {pz, py, px};
    endfunction

    // offer one word and wait for it to be taken; an optional idle burst
    // goes first, so gaps land wherever the pipeline happens to be
    task automatic send_dir(input logic [47:0] dir, input logic lst, input bit may_idle);
        if (may_idle && !quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dir;
        s_tlast  <= lst;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        n_sent++;
    endtask

    // random batches of 1..16 words, tlast on the final word of each batch;
    // idling is switched on or off per batch so there are clean stretches too
    task automatic send_random(input int count, input bit idle_ok);
        int left;
        int batch;
        bit idle_now;
        left = count;
        while (left > 0) begin
            batch    = $urandom_range(1, 16);
            idle_now = idle_ok && ($urandom_range(0, 2) != 0);
            if (batch > left)
                batch = left;
            for (int k = 0; k < batch; k++)
                send_dir(pick_dir(), k == batch - 1, idle_now);
            left -= batch;
        end
    endtask

    // sink: random stalls, one long hold-off on request, none in the tail
    initial begin
        m_tready  <= 1'b1;
        hold_done <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                m_tready  <= 1'b1;
                hold_done <= 1'b1;
            end else if (!quiet && i_rst_n && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // source and verdict
    initial begin
        n_sent   = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        hold_go  <= 1'b0;
        quiet    <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, tlast every fifth word and on the final one
        for (int k = 0; k < N_CORNER; k++)
            send_dir(CORNERS[k], (k % 5 == 4) || (k == N_CORNER - 1), 1'b1);

        // source pause until every color is back; pending is read only after
        // the checker has registered the word just taken
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);

        // sink holds off while the source keeps pushing: pipeline fills,
        // s_tready must drop and nothing may be lost or doubled
        hold_go <= 1'b1;
        send_random(N_HOLD, 1'b0);

        send_random(N_RAND, 1'b1);

        // tail: back to back on both sides
        quiet <= 1'b1;
        send_random(N_QUIET, 1'b0);
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Summary: %0d directions sent (%0d corners), %0d colors checked", n_sent,
                 N_CORNER, checked);
        $display("  unit, raw full-range and near-saturation vectors; %0d-cycle sink hold-off",
                 HOLD_CYC);
        if (pending != 0)
            $display("%0d expected colors never arrived", pending);
        if (errors == 0 && pending == 0) begin
            $display("PASS boy_surface_direction_to_rgb");
        end else begin
            $display("FAIL boy_surface_direction_to_rgb");
        end
        $finish;
    end

endmodule
